// ===== hw/rtl/quad_field_code_assert.svh =====
// Assertion macros of the quad field code RTL.
`ifndef QUAD_FIELD_CODE_ASSERT_SVH
`define QUAD_FIELD_CODE_ASSERT_SVH
`ifndef SYNTH
`define QFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define QFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define QFC_ASSERT(lbl, prop, msg)
`define QFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/qfc_pkg.sv =====
// Shared constants and types of the quad field code block.
package qfc_pkg;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned SCALE_WIDTH     = 50;

  typedef struct packed {
    logic                   degen;
    logic [SCALE_WIDTH-1:0] scale;
  } qfc_meta_t;
endpackage

// ===== hw/rtl/quad_field_code.sv =====
// Top level of the quad field code block: front end, four code lanes, output skid.
//
// Input beat: four points A, B, C, D (ax..py), signed fixed point, COORD_WIDTH
// bits with FRAC_BITS fraction bits. Output beat: C and D mapped by the
// similarity that sends A to the origin and B to (1,1), as four saturated
// codes, the squared A-B distance in scale_out_o, and two flags.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Pipeline: two front stages, four lane stages for product, sum, sign and
// overflow check, one stage per quotient bit of the restoring divider in
// each lane, and one clip stage, then the output register.
// Throughput: one beat per cycle; all four lanes and the front run in lockstep.
// When the receiver stalls, the output register holds its beat and the next
// finished beat drops into a one-entry skid register; only while the skid is
// full does stall_o rise and the whole pipeline hold.
// A equal to B gives degenerate_o high with all codes, scale and saturated zero.
// Reset clears all valid bits; the pipeline payload is not reset.
`include "quad_field_code_assert.svh"
module quad_field_code import qfc_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [COORD_WIDTH-1:0] code_c_x_o,
  output logic signed [COORD_WIDTH-1:0] code_c_y_o,
  output logic signed [COORD_WIDTH-1:0] code_d_x_o,
  output logic signed [COORD_WIDTH-1:0] code_d_y_o,
  output logic [SCALE_WIDTH-1:0]        scale_out_o,
  output logic                          degenerate_o,
  output logic                          saturated_o
);
  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned CW   = W + 2;
  localparam int unsigned SW   = 2 * W + 2;
  localparam int unsigned LAT  = W + 7;
  localparam int unsigned MD   = W + 4;
  localparam int unsigned RESW = 4 * W + SCALE_WIDTH + 2;

  logic en;
  logic [LAT-1:0] v_q;

  logic signed [CW-1:0] cxr, cyr, dxr, dyr, ncxr, ndxr, cs, sn;
  logic [SW-1:0]        s;
  qfc_meta_t            meta_f;
  qfc_meta_t            meta_q [MD];

  logic signed [W-1:0] code_cx, code_cy, code_dx, code_dy;
  logic                sat_cx, sat_cy, sat_dx, sat_dy;

  logic [RESW-1:0] res, out_q, skid_q;
  logic            out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic            take, load_out, load_skid, out_from_skid;
  qfc_meta_t       meta_o;

  // Hold the whole pipeline only while the skid register is occupied.
  assign en      = !skid_v_q;
  assign stall_o = skid_v_q;

  qfc_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i, .en_i(en),
    .ax_i, .ay_i, .bx_i, .by_i, .cx_i, .cy_i, .px_i, .py_i,
    .cxr_o(cxr), .cyr_o(cyr), .dxr_o(dxr), .dyr_o(dyr),
    .ncxr_o(ncxr), .ndxr_o(ndxr), .cs_o(cs), .sn_o(sn),
    .s_o(s), .meta_o(meta_f)
  );

  // x' = x*cos + y*sin, y' = y*cos - x*sin for C and D
  qfc_lane #(.W(W), .F(FRAC_BITS)) u_lane_cx (
    .clk_i, .en_i(en), .a_i(cxr), .ma_i(cs), .b_i(cyr), .mb_i(sn),
    .s_i(s), .code_o(code_cx), .sat_o(sat_cx)
  );
  qfc_lane #(.W(W), .F(FRAC_BITS)) u_lane_cy (
    .clk_i, .en_i(en), .a_i(ncxr), .ma_i(sn), .b_i(cyr), .mb_i(cs),
    .s_i(s), .code_o(code_cy), .sat_o(sat_cy)
  );
  qfc_lane #(.W(W), .F(FRAC_BITS)) u_lane_dx (
    .clk_i, .en_i(en), .a_i(dxr), .ma_i(cs), .b_i(dyr), .mb_i(sn),
    .s_i(s), .code_o(code_dx), .sat_o(sat_dx)
  );
  qfc_lane #(.W(W), .F(FRAC_BITS)) u_lane_dy (
    .clk_i, .en_i(en), .a_i(ndxr), .ma_i(sn), .b_i(dyr), .mb_i(cs),
    .s_i(s), .code_o(code_dy), .sat_o(sat_dy)
  );

  // Delay scale and degenerate flag to line up with the lane outputs.
  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_f;
      for (int k = 1; k < MD; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], valid_i};
    end
  end

  // Merge the lanes; force zero codes for a degenerate quad.
  assign meta_o = meta_q[MD-1];
  always_comb begin
    if (meta_o.degen) begin
      res = {{(4*W){1'b0}}, meta_o.scale, 1'b1, 1'b0};
    end else begin
      res = {code_cx, code_cy, code_dx, code_dy, meta_o.scale, 1'b0,
             sat_cx | sat_cy | sat_dx | sat_dy};
    end
  end

  // Output register plus skid: drain skid first, else take the pipeline beat.
  assign take = out_v_q && !stall_i;
  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_v_q) begin
      if (take) begin
        out_from_skid = 1'b1;
        skid_v_d      = 1'b0;
      end
    end else if (v_q[LAT-1]) begin
      if (!out_v_q || take) begin
        load_out = 1'b1;
        out_v_d  = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end
    end else if (take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign valid_o = out_v_q;
  assign {code_c_x_o, code_c_y_o, code_d_x_o, code_d_y_o,
          scale_out_o, degenerate_o, saturated_o} = out_q;

  `QFC_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid full while output empty")
  `QFC_ASSERT_NEXT(a_skid_holds_pipe, skid_v_q, $stable(v_q), "pipeline moved while skid full")
  `QFC_ASSERT_NEXT(a_accept_enters, valid_i && !stall_o, v_q[0], "accepted beat not in pipeline")
  `QFC_ASSERT(a_degen_zero, out_v_q && degenerate_o |-> (code_c_x_o == '0) && (code_c_y_o == '0) && (code_d_x_o == '0) && (code_d_y_o == '0) && !saturated_o, "degenerate beat with nonzero codes")
endmodule

// ===== hw/rtl/qfc_front.sv =====
// Front end: point differences, rotation terms, squared distance and scale.
module qfc_front import qfc_pkg::*; #(
  parameter int unsigned W = COORD_WIDTH_DEF,
  parameter int unsigned F = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [W-1:0]    ax_i,
  input  logic signed [W-1:0]    ay_i,
  input  logic signed [W-1:0]    bx_i,
  input  logic signed [W-1:0]    by_i,
  input  logic signed [W-1:0]    cx_i,
  input  logic signed [W-1:0]    cy_i,
  input  logic signed [W-1:0]    px_i,
  input  logic signed [W-1:0]    py_i,
  output logic signed [W+1:0]    cxr_o,
  output logic signed [W+1:0]    cyr_o,
  output logic signed [W+1:0]    dxr_o,
  output logic signed [W+1:0]    dyr_o,
  output logic signed [W+1:0]    ncxr_o,
  output logic signed [W+1:0]    ndxr_o,
  output logic signed [W+1:0]    cs_o,
  output logic signed [W+1:0]    sn_o,
  output logic [2*W+1:0]         s_o,
  output qfc_meta_t              meta_o
);
  localparam int unsigned DW  = W + 1;
  localparam int unsigned CW  = W + 2;
  localparam int unsigned SW  = 2 * DW;
  localparam int unsigned SHW = SW - F;
  localparam int unsigned XW  = SHW + SCALE_WIDTH;

  logic signed [DW-1:0] dx_q, dy_q, cxr_q, cyr_q, dxr_q, dyr_q;
  logic signed [CW-1:0] cxr2_q, cyr2_q, dxr2_q, dyr2_q, ncxr_q, ndxr_q, cs_q, sn_q;
  logic signed [SW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic                 degen_q;
  logic [SW-1:0]        s_d, s_q;
  logic [XW-1:0]        sh_ext;
  qfc_meta_t            meta_d, meta_q;

  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;
  assign s_d   = $unsigned(sqx_q) + $unsigned(sqy_q);
  assign sh_ext = XW'(s_d[SW-1:F]);

  always_comb begin
    meta_d.degen = degen_q;
    if (|sh_ext[XW-1:SCALE_WIDTH]) begin
      meta_d.scale = '1;
    end else begin
      meta_d.scale = sh_ext[SCALE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // differences against A
      dx_q  <= DW'(bx_i) - DW'(ax_i);
      dy_q  <= DW'(by_i) - DW'(ay_i);
      cxr_q <= DW'(cx_i) - DW'(ax_i);
      cyr_q <= DW'(cy_i) - DW'(ay_i);
      dxr_q <= DW'(px_i) - DW'(ax_i);
      dyr_q <= DW'(py_i) - DW'(ay_i);
      // rotation terms and squares
      cs_q    <= CW'(dy_q) + CW'(dx_q);
      sn_q    <= CW'(dy_q) - CW'(dx_q);
      cxr2_q  <= CW'(cxr_q);
      cyr2_q  <= CW'(cyr_q);
      dxr2_q  <= CW'(dxr_q);
      dyr2_q  <= CW'(dyr_q);
      ncxr_q  <= -CW'(cxr_q);
      ndxr_q  <= -CW'(dxr_q);
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      degen_q <= (dx_q == '0) && (dy_q == '0);
      // squared distance
      s_q    <= s_d;
      meta_q <= meta_d;
    end
  end

  assign cxr_o  = cxr2_q;
  assign cyr_o  = cyr2_q;
  assign dxr_o  = dxr2_q;
  assign dyr_o  = dyr2_q;
  assign ncxr_o = ncxr_q;
  assign ndxr_o = ndxr_q;
  assign cs_o   = cs_q;
  assign sn_o   = sn_q;
  assign s_o    = s_q;
  assign meta_o = meta_q;
endmodule

// ===== hw/rtl/qfc_lane.sv =====
// One code lane: dot product, then a pipelined restoring divide and clip.
module qfc_lane import qfc_pkg::*; #(
  parameter int unsigned W = COORD_WIDTH_DEF,
  parameter int unsigned F = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [W+1:0]  a_i,
  input  logic signed [W+1:0]  ma_i,
  input  logic signed [W+1:0]  b_i,
  input  logic signed [W+1:0]  mb_i,
  input  logic [2*W+1:0]       s_i,
  output logic signed [W-1:0]  code_o,
  output logic                 sat_o
);
  localparam int unsigned CW   = W + 2;
  localparam int unsigned SW   = 2 * W + 2;
  localparam int unsigned PW   = 2 * CW;
  localparam int unsigned NUMW = PW + 1;
  localparam int unsigned MW   = NUMW;
  localparam int unsigned NW   = MW + F;
  localparam int unsigned HW   = NW - W;
  localparam int unsigned RW   = SW + 1;
  localparam int unsigned CMPW = (HW > RW) ? HW : RW;

  logic signed [PW-1:0]   pa_d, pb_d, pa_q, pb_q;
  logic signed [NUMW-1:0] num_q;
  logic [MW-1:0]          mag3_q;
  logic                   neg3_q;
  logic [SW-1:0]          s1_q, s2_q;
  logic [NW-1:0]          nfull;
  logic [CMPW-1:0]        hi;

  logic [RW-1:0] rem_d [W+1];
  logic [RW-1:0] rem_q [W+1];
  logic [W-1:0]  quo_d [W+1];
  logic [W-1:0]  quo_q [W+1];
  logic [W-1:0]  low_d [W+1];
  logic [W-1:0]  low_q [W+1];
  logic [SW-1:0] sp_d  [W+1];
  logic [SW-1:0] sp_q  [W+1];
  logic [W:0]    neg_d, neg_q, ovf_d, ovf_q;

  logic [W-1:0]        q;
  logic                sat_d, sat_q;
  logic signed [W-1:0] code_d, code_q;

  assign pa_d  = a_i * ma_i;
  assign pb_d  = b_i * mb_i;
  assign nfull = {mag3_q, {F{1'b0}}};
  assign hi    = CMPW'(nfull[NW-1:W]);

  // Stage zero takes the high numerator part; the quotient fits W bits unless it overflows.
  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    rem_d[0] = hi[RW-1:0];
    quo_d[0] = '0;
    low_d[0] = nfull[W-1:0];
    sp_d[0]  = s2_q;
    neg_d[0] = neg3_q;
    ovf_d[0] = hi >= CMPW'(s2_q);
    for (int k = 0; k < W; k++) begin
      trial      = {rem_q[k][RW-2:0], low_q[k][W-1-k]};
      ge         = trial >= RW'(sp_q[k]);
      rem_d[k+1] = ge ? trial - RW'(sp_q[k]) : trial;
      quo_d[k+1] = {quo_q[k][W-2:0], ge};
      low_d[k+1] = low_q[k];
      sp_d[k+1]  = sp_q[k];
      neg_d[k+1] = neg_q[k];
      ovf_d[k+1] = ovf_q[k];
    end
  end

  assign q = quo_q[W];

  // Clip to the signed range and apply the sign.
  always_comb begin
    if (neg_q[W]) begin
      sat_d  = ovf_q[W] || (q[W-1] && (|q[W-2:0]));
      code_d = sat_d ? {1'b1, {(W-1){1'b0}}} : -$signed(q);
    end else begin
      sat_d  = ovf_q[W] || q[W-1];
      code_d = sat_d ? {1'b0, {(W-1){1'b1}}} : $signed(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      s1_q   <= s_i;
      num_q  <= NUMW'(pa_q) + NUMW'(pb_q);
      s2_q   <= s1_q;
      neg3_q <= num_q[NUMW-1];
      mag3_q <= num_q[NUMW-1] ? MW'(-num_q) : MW'(num_q);
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      low_q  <= low_d;
      sp_q   <= sp_d;
      neg_q  <= neg_d;
      ovf_q  <= ovf_d;
      code_q <= code_d;
      sat_q  <= sat_d;
    end
  end

  assign code_o = code_q;
  assign sat_o  = sat_q;
endmodule

// ===== test/quad_field_code_test.sv =====
// Self-checking testbench of the quad field code block.
module quad_field_code_test import qfc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW         = COORD_WIDTH_DEF;
  localparam int unsigned FB         = FRAC_BITS_DEF;
  localparam int unsigned PIPE_DEPTH = CW + 7;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned MAX_SHOWN  = 10;

  typedef logic signed [CW-1:0] coord_t;

  // One expected output beat.
  typedef struct {
    coord_t                 cx, cy, dx, dy;
    logic [SCALE_WIDTH-1:0] scale;
    logic                   degen;
    logic                   sat;
  } quad_code_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   valid_i = 1'b0;
  logic   stall_i = 1'b0;
  coord_t ax_i = '0, ay_i = '0, bx_i = '0, by_i = '0;
  coord_t cx_i = '0, cy_i = '0, px_i = '0, py_i = '0;
  logic   stall_o, valid_o, degenerate_o, saturated_o;
  coord_t code_c_x_o, code_c_y_o, code_d_x_o, code_d_y_o;
  logic [SCALE_WIDTH-1:0] scale_out_o;

  quad_code_t pending_codes[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  quad_field_code dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: the slowest legal run is far below this.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("quad_field_code_test: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: stall at the current idle rate.
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Exact quotient of one code lane, truncated toward zero, clipped to range.
  function automatic coord_t lane_code(input logic signed [127:0] num,
                                       input logic [127:0] sq, inout logic sat);
    logic [127:0] mag, quo, lim;
    lim = 128'd1 << (CW - 1);
    mag = num < 0 ? 128'(-num) : 128'(num);
    quo = (mag << FB) / sq;
    if (num < 0) begin
      if (quo > lim) begin
        sat = 1'b1;
        quo = lim;
      end
      return coord_t'(-quo);
    end
    if (quo >= lim) begin
      sat = 1'b1;
      quo = lim - 1;
    end
    return coord_t'(quo);
  endfunction

  // Map C and D into the frame that sends A to the origin and B to (1,1).
  function automatic quad_code_t quad_code(input coord_t ax, ay, bx, by,
                                           input coord_t cx, cy, qx, qy);
    logic signed [127:0] ddx, ddy, crx, cry, drx, dry, cosn, sinn;
    logic [127:0] sq, sc;
    quad_code_t r;
    ddx  = 128'(bx) - 128'(ax);
    ddy  = 128'(by) - 128'(ay);
    crx  = 128'(cx) - 128'(ax);
    cry  = 128'(cy) - 128'(ay);
    drx  = 128'(qx) - 128'(ax);
    dry  = 128'(qy) - 128'(ay);
    cosn = ddy + ddx;
    sinn = ddy - ddx;
    sq   = 128'(ddx * ddx + ddy * ddy);
    r = '{cx: '0, cy: '0, dx: '0, dy: '0, scale: '0, degen: 1'b0, sat: 1'b0};
    if (sq == 0) begin
      r.degen = 1'b1;
      return r;
    end
    r.cx = lane_code(crx * cosn + cry * sinn, sq, r.sat);
    r.cy = lane_code(-crx * sinn + cry * cosn, sq, r.sat);
    r.dx = lane_code(drx * cosn + dry * sinn, sq, r.sat);
    r.dy = lane_code(-drx * sinn + dry * cosn, sq, r.sat);
    sc = sq >> FB;
    r.scale = (sc >> SCALE_WIDTH) != 0 ? '1 : sc[SCALE_WIDTH-1:0];
    return r;
  endfunction

  // Drive one quad, hold it until accepted, then maybe idle the sender.
  task automatic send_quad(input coord_t ax, ay, bx, by, cx, cy, qx, qy);
    valid_i <= 1'b1;
    ax_i <= ax; ay_i <= ay; bx_i <= bx; by_i <= by;
    cx_i <= cx; cy_i <= cy; px_i <= qx; py_i <= qy;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_codes.push_back(quad_code(ax, ay, bx, by, cx, cy, qx, qy));
    if ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic report(input string field, input logic [63:0] want, got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch %s: expected %h, got %h", field, want, got);
  endtask

  // Compare every accepted output beat with the oldest expectation.
  always @(posedge clk_i) begin
    quad_code_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_codes.size() == 0) begin
        report("unexpected beat", '0, 64'(scale_out_o));
      end else begin
        want = pending_codes.pop_front();
        if (code_c_x_o !== want.cx) report("code_c_x", 64'(want.cx), 64'(code_c_x_o));
        if (code_c_y_o !== want.cy) report("code_c_y", 64'(want.cy), 64'(code_c_y_o));
        if (code_d_x_o !== want.dx) report("code_d_x", 64'(want.dx), 64'(code_d_x_o));
        if (code_d_y_o !== want.dy) report("code_d_y", 64'(want.dy), 64'(code_d_y_o));
        if (scale_out_o !== want.scale)
          report("scale_out", 64'(want.scale), 64'(scale_out_o));
        if (degenerate_o !== want.degen)
          report("degenerate", 64'(want.degen), 64'(degenerate_o));
        if (saturated_o !== want.sat)
          report("saturated", 64'(want.sat), 64'(saturated_o));
      end
    end
  end

  // Coordinate mix: small spans, some medium, some full range, a few extremes.
  function automatic coord_t pick_coord();
    case ($urandom_range(5))
      0, 1:    return coord_t'($signed($urandom_range(1 << 21)) - (1 << 20));
      2:       return coord_t'($signed($urandom_range(1 << 25)) - (1 << 24));
      3, 4:    return coord_t'($urandom);
      default: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx, mn, one;
    mx  = {1'b0, {(CW-1){1'b1}}};
    mn  = {1'b1, {(CW-1){1'b0}}};
    one = coord_t'(1) << FB;
    // A equals B: degenerate, codes forced to zero
    send_quad(0, 0, 0, 0, 0, 0, 0, 0);
    send_quad(mx, mn, mx, mn, one, one, mn, mx);
    send_quad(mn, mn, mn, mn, mx, mx, mx, mx);
    // unit frames: B lands on (1,1)
    send_quad(0, 0, one, 0, one, 0, 0, one);
    send_quad(0, 0, 0, one, one, one, -one, -one);
    send_quad(one, one, 2 * one, 2 * one, 0, 0, 3 * one, -one);
    // tiny span with far points: some lanes clip
    send_quad(0, 0, 1, 0, mx, mn, mn, mx);
    send_quad(0, 0, 0, 1, mn, mx, mx, mn);
    send_quad(mx, mx, mx - 1, mx, mn, mn, mn, mx);
    // widest spans and a few short ones
    send_quad(mn, mn, mx, mx, mx, mn, mn, mx);
    send_quad(mx, mn, mn, mx, 0, 0, mx, mx);
    send_quad(mn, mx, mx, mn, mn, mn, 0, 0);
    send_quad(mx, mx, mx, mx - 1, mx, mx, mn, mn);
    send_quad(-1, -1, 1, 1, -1, 1, 1, -1);
    send_quad(mn, 0, mx, 0, 0, mn, 0, mx);
  endtask

  task automatic test_random(input int unsigned count);
    coord_t ax, ay, bx, by;
    repeat (count) begin
      ax = pick_coord();
      ay = pick_coord();
      bx = pick_coord();
      by = pick_coord();
      case ($urandom_range(19))
        0:       begin bx = ax; by = ay; end
        1:       begin bx = ax + coord_t'($urandom_range(7)); by = ay; end
        default: ;
      endcase
      send_quad(ax, ay, bx, by, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 7;
    recv_idle_pct = 48;
    test_random(630);
    send_idle_pct = 48;
    recv_idle_pct = 7;
    test_random(630);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(630);
    drain();
    if (mismatches == 0) begin
      $display("quad_field_code_test: PASS");
    end else begin
      $display("quad_field_code_test: FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qfc_pkg.sv
hw/rtl/qfc_front.sv
hw/rtl/qfc_lane.sv
hw/rtl/quad_field_code.sv
test/quad_field_code_test.sv
